// File: rtl/core/vfsp_pkg.sv
// Package for the video frame sync pacer: field widths, register map, limits,
// payload beat types and the divide-by-three helper.
// No dependencies; compile first.
package vfsp_pkg;

  // Default width of the internal time values (video clock, A/V difference).
  localparam int VFSP_TIME_WIDTH = 48;

  // Fixed field widths.
  localparam int VFSP_STAMP_WIDTH  = 48;
  localparam int VFSP_DELAY_WIDTH  = 21;
  localparam int VFSP_PERIOD_WIDTH = 20;
  localparam int VFSP_TICK_WIDTH   = 32;

  // APB register port.
  localparam int VFSP_APB_DATA_WIDTH = 32;
  localparam int VFSP_APB_ADDR_WIDTH = 3;

  // Register reset values.
  localparam logic [VFSP_TICK_WIDTH-1:0]   VFSP_TICK_RESET   = 32'd728178;
  localparam logic [VFSP_PERIOD_WIDTH-1:0] VFSP_PERIOD_RESET = 20'd40000;

  // Pacing thresholds in microseconds.
  localparam int VFSP_DROP_LIMIT  = 500000;
  localparam int VFSP_NUDGE_LIMIT = 3000;
  localparam int VFSP_BIG_LIMIT   = 1000000;
  localparam int VFSP_HUGE_LIMIT  = 10000000;

  // Register indexes, decoded from paddr[2].
  typedef enum logic [0:0] {
    REG_TICK_US_Q16     = 1'b0,
    REG_FRAME_PERIOD_US = 1'b1
  } vfsp_reg_t;

  // One packet timestamp beat.
  typedef struct packed {
    logic signed [VFSP_STAMP_WIDTH-1:0] pts;
    logic signed [VFSP_STAMP_WIDTH-1:0] dts;
    logic signed [VFSP_STAMP_WIDTH-1:0] master_clock_us;
    logic                               master_clock_valid;
  } vfsp_packet_t;

  // One pacing decision beat.
  typedef struct packed {
    logic                               drop_frame;
    logic [VFSP_DELAY_WIDTH-1:0]        delay_us;
    logic signed [VFSP_STAMP_WIDTH-1:0] video_clock_out;
  } vfsp_result_t;

  // Exact floor(x / 3) for x below 2^22, by reciprocal multiplication.
  function automatic logic [VFSP_DELAY_WIDTH-1:0] div3(input logic [21:0] x);
    logic [44:0] prod;
    prod = 45'(x) * 45'h555556;
    return prod[44:24];
  endfunction

endpackage

// File: rtl/core/vfsp_if.sv
// Valid/ready stream interfaces for the video frame sync pacer.
// Depends on vfsp_pkg for the payload beat types.
interface vfsp_packet_if import vfsp_pkg::*; ();
  logic         valid;
  logic         ready;
  vfsp_packet_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface vfsp_result_if import vfsp_pkg::*; ();
  logic         valid;
  logic         ready;
  vfsp_result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/video_frame_sync_pacer.sv
// Top level of the video frame sync pacer: four-stage pacing pipeline and APB registers.
// Depends on vfsp_pkg and the stream interfaces in vfsp_if.sv.
//
// Unless the result side stalls it, the pacer takes one packet beat per clock cycle and
// holds one result beat per packet until the result side is ready. The four pipeline
// stages are the tick-to-microsecond partial products, their combination with saturation
// and the pts/dts choice, the video clock and A/V difference update, and the frame delay
// update that drives the result register. The video clock and the frame delay each
// close their feedback loop within one stage, which is what keeps the rate at one beat
// a cycle. A stalled result side fills the pipeline before the packet side sees ready
// go low. Registers: tick_us_q16 at byte address 0, frame_period_us at address 4;
// write them only while the pipeline is empty.
module video_frame_sync_pacer import vfsp_pkg::*; #(
  parameter int TIME_WIDTH = VFSP_TIME_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [VFSP_APB_ADDR_WIDTH-1:0] paddr,
  input  logic [VFSP_APB_DATA_WIDTH-1:0] pwdata,
  output logic [VFSP_APB_DATA_WIDTH-1:0] prdata,
  output logic                           pready,
  vfsp_packet_if.sink                    packet,
  vfsp_result_if.source                  pacing
);

  localparam int TW = TIME_WIDTH;
  localparam logic [63:0] TMAX_U   = (64'd1 << (TW - 1)) - 64'd1;
  localparam logic [63:0] TMIN_MAG = 64'd1 << (TW - 1);
  localparam logic signed [63:0] TMAX_S = $signed(TMAX_U);
  localparam logic signed [63:0] TMIN_S = -TMAX_S - 64'sd1;
  localparam logic signed [TW-1:0] TMAX_T = {1'b0, {(TW - 1){1'b1}}};
  localparam logic signed [TW-1:0] TMIN_T = {1'b1, {(TW - 1){1'b0}}};
  localparam logic signed [TW-1:0] DROP_L   = TW'(VFSP_DROP_LIMIT);
  localparam logic signed [TW-1:0] NUDGE_HI = TW'(VFSP_NUDGE_LIMIT);
  localparam logic signed [TW-1:0] NUDGE_LO = -NUDGE_HI;
  localparam logic signed [TW-1:0] BIG_HI   = TW'(VFSP_BIG_LIMIT);
  localparam logic signed [TW-1:0] BIG_LO   = -BIG_HI;
  localparam logic signed [TW-1:0] HUGE_HI  = TW'(VFSP_HUGE_LIMIT);
  localparam logic signed [TW-1:0] HUGE_LO  = -HUGE_HI;

  // Combine the partial products into a saturated signed time.
  function automatic logic [TW-1:0] to_time(input logic neg, input logic [47:0] hi,
                                            input logic [47:0] lo_sh);
    logic [63:0]   q;
    logic [63:0]   q_neg;
    logic [TW-1:0] t;
    q     = {hi, 16'd0} + {16'd0, lo_sh};
    q_neg = 64'd0 - q;
    if (neg) begin
      t = (hi[47] || (q > TMIN_MAG)) ? TMIN_T : q_neg[TW-1:0];
    end else begin
      t = (hi[47] || (q > TMAX_U)) ? TMAX_T : q[TW-1:0];
    end
    return t;
  endfunction

  // Keep a scaled delay between half and twice the frame period.
  function automatic logic [VFSP_DELAY_WIDTH-1:0] clamp_delay(
    input logic [21:0]                   c,
    input logic [VFSP_PERIOD_WIDTH-1:0]  r,
    input logic [VFSP_DELAY_WIDTH-1:0]   r2,
    input logic [VFSP_DELAY_WIDTH-1:0]   r23
  );
    logic [VFSP_DELAY_WIDTH-1:0] d;
    if ({c, 1'b0} < {3'd0, r}) begin
      d = r23;
    end else if (c > {1'b0, r2}) begin
      d = r2;
    end else begin
      d = c[VFSP_DELAY_WIDTH-1:0];
    end
    return d;
  endfunction

  // Configuration registers and derived period values.
  logic [VFSP_TICK_WIDTH-1:0]   tick_us_q16;
  logic [VFSP_PERIOD_WIDTH-1:0] frame_period_us;
  logic [VFSP_DELAY_WIDTH-1:0]  period_two_thirds;
  logic [VFSP_DELAY_WIDTH-1:0]  period_double;

  // Pacing state.
  logic signed [TW-1:0]        video_clock_us;
  logic signed [TW-1:0]        last_diff_us;
  logic [VFSP_DELAY_WIDTH-1:0] frame_delay_us;

  // Pipeline occupancy and flow.
  logic a_valid, b_valid, c_valid, d_valid;
  logic move_ab, move_bc, move_cd;
  logic a_free, b_free, c_free, d_free;
  logic accept;

  // Stage A registers: partial products.
  logic        a_pts_neg, a_dts_neg;
  logic [47:0] a_pts_hi, a_pts_lo, a_dts_hi, a_dts_lo;
  logic [47:0] a_master;
  logic        a_mvalid;

  // Stage B registers: packet time and clipped master clock.
  logic signed [TW-1:0] b_time;
  logic signed [TW-1:0] b_master;
  logic                 b_mvalid;

  // Stage C registers: video clock and difference.
  logic signed [TW-1:0] c_diff;
  logic signed [TW-1:0] c_vclk;

  // Result register.
  logic                        res_drop;
  logic [VFSP_DELAY_WIDTH-1:0] res_delay;
  logic [47:0]                 res_vclock;

  // APB access: always ready, registers decoded from paddr[2].
  assign pready = 1'b1;

  always_comb begin
    case (vfsp_reg_t'(paddr[2]))
      REG_TICK_US_Q16:     prdata = tick_us_q16;
      REG_FRAME_PERIOD_US: prdata = {{(VFSP_APB_DATA_WIDTH - VFSP_PERIOD_WIDTH){1'b0}},
                                     frame_period_us};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_us_q16     <= VFSP_TICK_RESET;
      frame_period_us <= VFSP_PERIOD_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (vfsp_reg_t'(paddr[2]))
        REG_TICK_US_Q16:     tick_us_q16 <= pwdata;
        REG_FRAME_PERIOD_US: frame_period_us <= pwdata[VFSP_PERIOD_WIDTH-1:0];
        default:             ;
      endcase
    end
  end

  // Two thirds of the period is registered from the period register.
  assign period_double = {frame_period_us, 1'b0};

  always_ff @(posedge clk) begin
    period_two_thirds <= div3({1'b0, frame_period_us, 1'b0});
  end

  // Pipeline flow: each stage moves when the next one is empty or moving.
  assign d_free  = !d_valid || pacing.ready;
  assign move_cd = c_valid && d_free;
  assign c_free  = !c_valid || move_cd;
  assign move_bc = b_valid && c_free;
  assign b_free  = !b_valid || move_bc;
  assign move_ab = a_valid && b_free;
  assign a_free  = !a_valid || move_ab;
  assign packet.ready = a_free;
  assign accept  = packet.valid && a_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      a_valid <= accept || (a_valid && !move_ab);
      b_valid <= move_ab || (b_valid && !move_bc);
      c_valid <= move_bc || (c_valid && !move_cd);
      d_valid <= move_cd || (d_valid && !pacing.ready);
    end
  end

  // Stage A: timestamp magnitudes times the time base, split at bit 32.
  logic [47:0] pts_mag, dts_mag;
  logic [47:0] pts_hi, dts_hi;
  logic [63:0] pts_lo, dts_lo;

  always_comb begin
    pts_mag = packet.payload.pts[47] ? 48'd0 - packet.payload.pts : packet.payload.pts;
    dts_mag = packet.payload.dts[47] ? 48'd0 - packet.payload.dts : packet.payload.dts;
    pts_hi  = 48'(pts_mag[47:32]) * 48'(tick_us_q16);
    dts_hi  = 48'(dts_mag[47:32]) * 48'(tick_us_q16);
    pts_lo  = 64'(pts_mag[31:0]) * 64'(tick_us_q16);
    dts_lo  = 64'(dts_mag[31:0]) * 64'(tick_us_q16);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_pts_neg <= packet.payload.pts[47];
      a_dts_neg <= packet.payload.dts[47];
      a_pts_hi  <= pts_hi;
      a_dts_hi  <= dts_hi;
      a_pts_lo  <= pts_lo[63:16];
      a_dts_lo  <= dts_lo[63:16];
      a_master  <= packet.payload.master_clock_us;
      a_mvalid  <= packet.payload.master_clock_valid;
    end
  end

  // Stage B: saturated times, dts fallback, master clock clipped to the time range.
  logic signed [TW-1:0] t_pts, t_dts;
  logic signed [63:0]   master_wide;
  logic signed [TW-1:0] master_clip;

  always_comb begin
    t_pts       = to_time(a_pts_neg, a_pts_hi, a_pts_lo);
    t_dts       = to_time(a_dts_neg, a_dts_hi, a_dts_lo);
    master_wide = 64'($signed(a_master));
    if (master_wide > TMAX_S) begin
      master_clip = TMAX_T;
    end else if (master_wide < TMIN_S) begin
      master_clip = TMIN_T;
    end else begin
      master_clip = master_wide[TW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (move_ab) begin
      b_time   <= t_pts[TW-1] ? t_dts : t_pts;
      b_master <= master_clip;
      b_mvalid <= a_mvalid;
    end
  end

  // Stage C: the video clock never steps back; the difference saturates.
  logic signed [TW-1:0] vclk_next;
  logic signed [TW:0]   diff_wide;
  logic signed [TW-1:0] diff_calc;
  logic signed [TW-1:0] diff_next;

  always_comb begin
    vclk_next = (b_time < video_clock_us) ? video_clock_us : b_time;
    diff_wide = {b_master[TW-1], b_master} - {vclk_next[TW-1], vclk_next};
    if (diff_wide[TW] != diff_wide[TW-1]) begin
      diff_calc = diff_wide[TW] ? TMIN_T : TMAX_T;
    end else begin
      diff_calc = diff_wide[TW-1:0];
    end
    diff_next = b_mvalid ? diff_calc : last_diff_us;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      video_clock_us <= '0;
      last_diff_us   <= '0;
    end else if (move_bc) begin
      video_clock_us <= vclk_next;
      last_diff_us   <= diff_next;
    end
  end

  always_ff @(posedge clk) begin
    if (move_bc) begin
      c_diff <= diff_next;
      c_vclk <= vclk_next;
    end
  end

  // Stage D: drop decision and frame delay steering.
  logic                        drop_calc;
  logic [VFSP_DELAY_WIDTH-1:0] delay_down;
  logic [22:0]                 delay_triple;
  logic [VFSP_DELAY_WIDTH-1:0] delay_next;
  logic [63:0]                 vclk_wide;

  always_comb begin
    drop_calc    = c_diff >= DROP_L;
    delay_down   = div3({frame_delay_us, 1'b0});
    delay_triple = 23'(frame_delay_us) + 23'({frame_delay_us, 1'b0});
    delay_next   = frame_delay_us;
    if (c_diff > NUDGE_HI) begin
      delay_next = clamp_delay({1'b0, delay_down}, frame_period_us, period_double,
                               period_two_thirds);
    end else if (c_diff < NUDGE_LO) begin
      delay_next = clamp_delay(delay_triple[22:1], frame_period_us, period_double,
                               period_two_thirds);
    end else if (c_diff == '0) begin
      delay_next = {1'b0, frame_period_us};
    end
    if (c_diff > BIG_HI) begin
      delay_next = '0;
    end
    if (c_diff < BIG_LO) begin
      delay_next = period_double;
    end
    if (c_diff > HUGE_HI || c_diff < HUGE_LO) begin
      delay_next = {1'b0, frame_period_us};
    end
    vclk_wide = 64'(c_vclk);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_delay_us <= '0;
    end else if (move_cd && !drop_calc) begin
      frame_delay_us <= delay_next;
    end
  end

  always_ff @(posedge clk) begin
    if (move_cd) begin
      res_drop   <= drop_calc;
      res_delay  <= drop_calc ? frame_delay_us : delay_next;
      res_vclock <= vclk_wide[47:0];
    end
  end

  // Result beat.
  assign pacing.valid                   = d_valid;
  assign pacing.payload.drop_frame      = res_drop;
  assign pacing.payload.delay_us        = res_delay;
  assign pacing.payload.video_clock_out = res_vclock;

  // The video clock only moves forward.
  assert property (@(posedge clk) disable iff (rst)
    move_bc |=> video_clock_us >= $past(video_clock_us))
    else $error("video clock stepped back");

  // Packet side stalls only when every stage holds a beat.
  assert property (@(posedge clk) disable iff (rst)
    !packet.ready |-> (a_valid && b_valid && c_valid && d_valid))
    else $error("packet side stalled with an empty stage");

  // A waiting result always shows the kept frame delay.
  assert property (@(posedge clk) disable iff (rst)
    pacing.valid |-> (pacing.payload.delay_us == frame_delay_us))
    else $error("result delay differs from kept frame delay");

endmodule

// File: sim/vfsp_pacing_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the video frame sync pacer: follows register writes on the APB port,
// predicts each pacing decision from the packet beats and checks the result beats.
// Depends on vfsp_pkg and the stream interfaces in vfsp_if.sv.
module vfsp_pacing_checker import vfsp_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [VFSP_APB_ADDR_WIDTH-1:0] paddr,
  input  logic [VFSP_APB_DATA_WIDTH-1:0] pwdata,
  vfsp_packet_if                         packet,
  vfsp_result_if                         pacing,
  output int unsigned                    open_count,
  output int unsigned                    fail_count,
  output int unsigned                    checked_count,
  output int unsigned                    drop_count
);

  localparam int TW = VFSP_TIME_WIDTH;
  localparam longint TIME_MAX = (longint'(1) <<< (TW - 1)) - 1;
  localparam longint TIME_MIN = -TIME_MAX - 1;
  localparam logic [95:0] TIME_MAX_MAG = 96'(TIME_MAX);

  // Shadow registers and pacing state.
  logic [VFSP_TICK_WIDTH-1:0]   tick_q16;
  logic [VFSP_PERIOD_WIDTH-1:0] period_us;
  logic [VFSP_DELAY_WIDTH-1:0]  frame_delay;
  longint                       shadow_clock;
  longint                       last_diff;
  vfsp_result_t                 decision_q[$];
  int unsigned                  fails;
  int unsigned                  checks;
  int unsigned                  drops;

  // Ticks times the Q16.16 time base, truncated toward zero and saturated to the time range.
  function automatic longint stamp_to_us(logic signed [VFSP_STAMP_WIDTH-1:0] ticks,
                                         logic [VFSP_TICK_WIDTH-1:0] tick);
    logic [VFSP_STAMP_WIDTH-1:0] mag;
    logic [95:0]                 scaled;
    mag = ticks[VFSP_STAMP_WIDTH-1] ? -ticks : ticks;
    scaled = (96'(mag) * 96'(tick)) >> 16;
    if (!ticks[VFSP_STAMP_WIDTH-1])
      return (scaled > TIME_MAX_MAG) ? TIME_MAX : longint'(scaled[63:0]);
    if (scaled > TIME_MAX_MAG + 96'd1)
      return TIME_MIN;
    return -longint'(scaled[63:0]);
  endfunction

  function automatic longint clip_time(longint value);
    if (value > TIME_MAX)
      return TIME_MAX;
    if (value < TIME_MIN)
      return TIME_MIN;
    return value;
  endfunction

  // Keeps a nudged delay between half and twice the frame period.
  function automatic longint fit_delay(longint delay, longint rate);
    if (2 * delay < rate)
      return 2 * rate / 3;
    if (delay > 2 * rate)
      return 2 * rate;
    return delay;
  endfunction

  // Advances the pacing state by one packet and returns the decision it yields.
  function automatic vfsp_result_t pace_frame(vfsp_packet_t beat);
    longint       stamp;
    longint       diff;
    longint       rate;
    longint       delay;
    vfsp_result_t decision;
    rate = longint'(period_us);
    delay = longint'(frame_delay);

    // The packet time falls back to dts and never runs behind the video clock.
    stamp = stamp_to_us(beat.pts, tick_q16);
    if (stamp < 0)
      stamp = stamp_to_us(beat.dts, tick_q16);
    if (stamp < shadow_clock)
      stamp = shadow_clock;
    shadow_clock = stamp;

    // An unknown master clock keeps the previous difference.
    if (beat.master_clock_valid)
      last_diff = clip_time(longint'($signed(beat.master_clock_us)) - shadow_clock);
    diff = last_diff;

    decision.drop_frame = (diff >= VFSP_DROP_LIMIT);
    if (!decision.drop_frame) begin
      if (diff > VFSP_NUDGE_LIMIT)
        delay = fit_delay(delay * 2 / 3, rate);
      else if (diff < -VFSP_NUDGE_LIMIT)
        delay = fit_delay(delay * 3 / 2, rate);
      else if (diff == 0)
        delay = rate;
      if (diff > VFSP_BIG_LIMIT)
        delay = 0;
      if (diff < -VFSP_BIG_LIMIT)
        delay = 2 * rate;
      if (diff > VFSP_HUGE_LIMIT || diff < -VFSP_HUGE_LIMIT)
        delay = rate;
      frame_delay = delay[VFSP_DELAY_WIDTH-1:0];
    end
    decision.delay_us = frame_delay;
    decision.video_clock_out = shadow_clock[VFSP_STAMP_WIDTH-1:0];
    return decision;
  endfunction

  // Result beats are checked before packet beats of the same edge are predicted.
  always @(posedge clk) begin : monitor
    vfsp_result_t want;
    if (rst) begin
      tick_q16 = VFSP_TICK_RESET;
      period_us = VFSP_PERIOD_RESET;
      frame_delay = '0;
      shadow_clock = 0;
      last_diff = 0;
      decision_q.delete();
      fails = 0;
      checks = 0;
      drops = 0;
    end else begin
      if (pacing.valid && pacing.ready) begin
        if (decision_q.size() == 0) begin
          $display("%0t: unexpected result beat: drop %0b delay %0d clock %0d", $time,
                   pacing.payload.drop_frame, pacing.payload.delay_us,
                   $signed(pacing.payload.video_clock_out));
          fails++;
        end else begin
          want = decision_q.pop_front();
          checks++;
          if (want.drop_frame)
            drops++;
          if (pacing.payload.drop_frame !== want.drop_frame) begin
            $display("%0t: drop_frame expected %0b, got %0b", $time, want.drop_frame,
                     pacing.payload.drop_frame);
            fails++;
          end
          if (pacing.payload.delay_us !== want.delay_us) begin
            $display("%0t: delay_us expected %0d, got %0d", $time, want.delay_us,
                     pacing.payload.delay_us);
            fails++;
          end
          if (pacing.payload.video_clock_out !== want.video_clock_out) begin
            $display("%0t: video_clock_out expected %0d, got %0d", $time,
                     $signed(want.video_clock_out), $signed(pacing.payload.video_clock_out));
            fails++;
          end
        end
      end

      // Register writes must come only while the pipeline is empty; not enforced here.
      if (psel && penable && pwrite && pready) begin
        case (vfsp_reg_t'(paddr[2]))
          REG_TICK_US_Q16:     tick_q16 = pwdata[VFSP_TICK_WIDTH-1:0];
          REG_FRAME_PERIOD_US: period_us = pwdata[VFSP_PERIOD_WIDTH-1:0];
          default: ;
        endcase
      end

      if (packet.valid && packet.ready)
        decision_q.push_back(pace_frame(packet.payload));
    end
    open_count <= decision_q.size();
    fail_count <= fails;
    checked_count <= checks;
    drop_count <= drops;
  end

endmodule

// File: sim/video_frame_sync_pacer_tb.sv
`timescale 1ns / 1ps
// Testbench top for the video frame sync pacer: clock, reset, APB register writes,
// packet stimulus with random idling, and the verdict from vfsp_pacing_checker.
// Depends on vfsp_pkg, vfsp_if.sv, the pacer RTL and vfsp_pacing_checker.
module video_frame_sync_pacer_tb import vfsp_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam longint STAMP_MAX = (longint'(1) <<< (VFSP_STAMP_WIDTH - 1)) - 1;
  localparam longint STAMP_MIN = -STAMP_MAX - 1;
  localparam longint EDGE_OFFSETS[10] = '{3000, -3000, 3001, -3001, 499999, 500000,
                                          -1000000, -1000001, -10000000, -10000001};

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [VFSP_APB_ADDR_WIDTH-1:0] paddr;
  logic [VFSP_APB_DATA_WIDTH-1:0] pwdata;
  logic [VFSP_APB_DATA_WIDTH-1:0] prdata;
  logic                           pready;

  vfsp_packet_if packet();
  vfsp_result_if pacing();

  int unsigned open_count;
  int unsigned fail_count;
  int unsigned checked_count;
  int unsigned drop_count;
  int unsigned cycle_count = 0;
  int unsigned sent_count = 0;
  int unsigned setting_count = 1;

  // Stimulus side view of the stream: current time base, stream position and a
  // running guess of the video clock used to aim the master clock.
  bit                         idle_on = 1'b1;
  logic [VFSP_TICK_WIDTH-1:0] tick_now = VFSP_TICK_RESET;
  int unsigned                step_cap = 4000;
  longint                     stream_ticks = 0;
  longint                     clock_guess = 0;

  always #2 clk = ~clk;

  video_frame_sync_pacer i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .packet  (packet),
    .pacing  (pacing)
  );

  vfsp_pacing_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .packet        (packet),
    .pacing        (pacing),
    .open_count    (open_count),
    .fail_count    (fail_count),
    .checked_count (checked_count),
    .drop_count    (drop_count)
  );

  // Hard stop in case the pipeline hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("video_frame_sync_pacer_tb NOT OK");
      $finish;
    end
  end

  // Result side backpressure: random stall bursts between ready runs while idling is on.
  initial begin
    pacing.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        pacing.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      pacing.ready <= 1'b1;
      repeat ($urandom_range(0, 11)) @(posedge clk);
    end
  end

  // Rough packet time in microseconds, good enough to aim the master clock.
  function automatic longint stamp_guess(longint ticks);
    logic [95:0] scaled;
    scaled = (96'(ticks < 0 ? -ticks : ticks) * 96'(tick_now)) >> 16;
    return (ticks < 0) ? -longint'(scaled[63:0]) : longint'(scaled[63:0]);
  endfunction

  // One APB write; psel stays high so that writes can follow back to back.
  task automatic write_reg(input vfsp_reg_t index, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic wait_empty();
    packet.valid <= 1'b0;
    do @(posedge clk); while (open_count != 0);
  endtask

  // Drains the pipeline, then writes both registers and restarts the stream ahead
  // of the video clock in the new time base.
  task automatic set_pacing(input logic [31:0] tick, input logic [19:0] period);
    wait_empty();
    write_reg(REG_TICK_US_Q16, tick);
    write_reg(REG_FRAME_PERIOD_US, 32'(period));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tick_now = tick;
    setting_count++;
    step_cap = (tick > 32'd536870) ? (32'h8000_0000 / tick) + 1 : 4000;
    if (tick != 0)
      stream_ticks = clock_guess * 65536 / longint'(tick) + 1;
  endtask

  // Sends one packet beat; with aim set the master clock is an offset from the
  // guessed video clock.
  task automatic send_packet(input longint pts, input longint dts, input longint master,
                             input bit master_ok, input bit aim);
    vfsp_packet_t beat;
    longint       stamp;
    beat.pts = pts[VFSP_STAMP_WIDTH-1:0];
    beat.dts = dts[VFSP_STAMP_WIDTH-1:0];
    beat.master_clock_valid = master_ok;
    stamp = stamp_guess(longint'(beat.pts));
    if (stamp < 0)
      stamp = stamp_guess(longint'(beat.dts));
    if (stamp > clock_guess)
      clock_guess = stamp;
    beat.master_clock_us = aim ? VFSP_STAMP_WIDTH'(clock_guess + master)
                               : master[VFSP_STAMP_WIDTH-1:0];
    if (idle_on && $urandom_range(0, 3) == 0) begin
      packet.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    packet.valid <= 1'b1;
    packet.payload <= beat;
    do @(posedge clk); while (!packet.ready);
    sent_count++;
  endtask

  // Next frame of a well-formed stream: pts never moves back and dts trails it.
  task automatic next_frame(input int unsigned step, input longint offset, input bit master_ok);
    stream_ticks += step;
    send_packet(stream_ticks, stream_ticks - longint'($urandom_range(0, 30)), offset,
                master_ok, 1'b1);
  endtask

  // Mostly well-formed frames with every class of A/V offset, plus packets whose
  // pts is negative and whose master clock is arbitrary.
  task automatic random_phase(input int count);
    longint offset;
    longint noise_pts;
    longint noise_dts;
    repeat (count) begin
      if ($urandom_range(0, 4) != 0) begin
        case ($urandom_range(0, 9))
          0: offset = 0;
          1: offset = longint'($urandom_range(0, 6000)) - 3000;
          2: offset = longint'($urandom_range(3001, 499999));
          3: offset = -longint'($urandom_range(3001, 999999));
          4: offset = longint'($urandom_range(500000, 20000000));
          5: offset = -longint'($urandom_range(1000001, 10000000));
          6: offset = -longint'({$urandom_range(0, 255), $urandom}) - 10000001;
          7: offset = EDGE_OFFSETS[$urandom_range(0, 9)];
          default: offset = longint'($urandom_range(0, 120000)) - 60000;
        endcase
        next_frame($urandom_range(0, step_cap), offset, $urandom_range(0, 7) != 0);
      end else begin
        noise_pts = longint'({$urandom, $urandom}) | STAMP_MIN;
        if ($urandom_range(0, 3) == 0)
          noise_dts = longint'($urandom_range(0, 1000));
        else
          noise_dts = longint'({$urandom, $urandom}) | STAMP_MIN;
        send_packet(noise_pts, noise_dts, longint'({$urandom, $urandom}),
                    1'($urandom_range(0, 1)), 1'b0);
      end
    end
  endtask

  initial begin : stimulus
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    packet.valid <= 1'b0;
    packet.payload <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed frames at the reset setting: zero difference, nudges down into the
    // lower clamp and up into the upper clamp, the nudge and drop boundaries, reuse of
    // the last difference, the large-lag and huge-difference overrides.
    next_frame(0, 0, 1'b1);
    next_frame(90, 5000, 1'b1);
    next_frame(90, 5000, 1'b1);
    repeat (4) next_frame(90, -5000, 1'b1);
    next_frame(90, 3000, 1'b1);
    next_frame(90, -3000, 1'b1);
    next_frame(90, 3001, 1'b1);
    next_frame(90, -3001, 1'b1);
    next_frame(90, 499999, 1'b1);
    next_frame(90, 500000, 1'b1);
    next_frame(90, 0, 1'b0);
    next_frame(90, -1000001, 1'b1);
    next_frame(90, -10000001, 1'b1);
    next_frame(90, 10000001, 1'b1);
    next_frame(0, -1000000, 1'b1);

    // A pts behind the video clock, a negative pts time falling back to dts, and
    // master clock extremes that saturate the difference.
    send_packet(stream_ticks - 500, stream_ticks - 510, 0, 1'b1, 1'b1);
    send_packet(-1, stream_ticks + 200, 0, 1'b1, 1'b1);
    send_packet(STAMP_MIN, STAMP_MIN, STAMP_MIN, 1'b1, 1'b0);
    send_packet(-1, -1, STAMP_MAX, 1'b1, 1'b0);
    send_packet(-5, -7, STAMP_MIN, 1'b0, 1'b0);

    // Zero frame period.
    set_pacing(VFSP_TICK_RESET, 20'd0);
    next_frame(90, 0, 1'b1);
    next_frame(90, 5000, 1'b1);
    next_frame(90, -5000, 1'b1);
    next_frame(90, -2000000, 1'b1);

    // Random part over several register settings, extremes included.
    set_pacing(32'd0, 20'd1000000);
    random_phase(100);
    set_pacing(32'd65536, 20'd16667);
    random_phase(100);
    set_pacing(32'hFFFF_FFFF, 20'd1);
    random_phase(100);
    set_pacing(32'd1, 20'd0);
    random_phase(100);
    set_pacing(32'($urandom_range(1, 32'h0100_0000)), 20'($urandom_range(0, 1000000)));
    random_phase(100);
    set_pacing(32'd728178, 20'd40000);
    random_phase(100);
    set_pacing($urandom, 20'($urandom_range(0, 1000000)));
    random_phase(100);

    // Closing stretch without idling on either side.
    set_pacing(VFSP_TICK_RESET, VFSP_PERIOD_RESET);
    idle_on = 1'b0;
    random_phase(100);

    // The video clock never moves back, so the saturating times come last.
    set_pacing(32'hFFFF_FFFF, 20'd1000000);
    send_packet(STAMP_MAX, STAMP_MAX, STAMP_MIN, 1'b1, 1'b0);
    send_packet(STAMP_MIN, STAMP_MAX, STAMP_MAX, 1'b1, 1'b0);
    send_packet(STAMP_MIN, STAMP_MIN, 0, 1'b1, 1'b0);
    send_packet(0, 0, STAMP_MAX, 1'b0, 1'b0);

    wait_empty();
    repeat (16) @(posedge clk);
    $display("Sent %0d packets over %0d register settings with random idling on both sides.",
             sent_count, setting_count);
    $display("Checked %0d pacing decisions, %0d of them dropped frames.", checked_count,
             drop_count);
    if (fail_count == 0)
      $display("video_frame_sync_pacer_tb OK");
    else
      $display("video_frame_sync_pacer_tb NOT OK");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/vfsp_pkg.sv
rtl/core/vfsp_if.sv
rtl/core/video_frame_sync_pacer.sv
sim/vfsp_pacing_checker.sv
sim/video_frame_sync_pacer_tb.sv
